### design/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

    // Field widths of the request and response words and the config register.
    localparam int CMD_W  = 1;
    localparam int REQ_W  = 15;
    localparam int OFF_W  = 14;
    localparam int FREE_W = 15;
    localparam int CFG_W  = 15;

    // Pool geometry.
    localparam int POOL_BYTES_DEF = 16384;
    localparam int RESET_POOL     = 16384;
    localparam int HDR_BYTES      = 4;
    localparam int MIN_TAIL       = 8;

    // Command codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Register map (byte address).
    localparam logic REG_POOL_BYTES = 1'b0;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_A_SPLIT,
        ST_R_RD,
        ST_R_EV,
        ST_W_RD,
        ST_W_EV,
        ST_DONE
    } ffpa_state_t;

endpackage

`default_nettype wire

### design/ffpa_req_if.sv
`default_nettype none

interface ffpa_req_if
    import ffpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;

    modport source (output valid, command, request_bytes, payload_offset, input ready);
    modport sink   (input valid, command, request_bytes, payload_offset, output ready);
endinterface

`default_nettype wire

### design/ffpa_rsp_if.sv
`default_nettype none

interface ffpa_rsp_if
    import ffpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [OFF_W-1:0]  granted_offset;
    logic [FREE_W-1:0] free_space;

    modport source (output valid, ok, granted_offset, free_space, input ready);
    modport sink   (input valid, ok, granted_offset, free_space, output ready);
endinterface

`default_nettype wire

### design/first_fit_pool_allocator.sv
`default_nettype none

// First-fit pool allocator. Headers live in one block RAM with one slot per
// 4 bytes of pool; every header visit is a read issue step, then an evaluate
// step, because the next block address depends on the size just read.
// An allocate walks the blocks up to the first fit (a split adds a step that
// writes the block's own header); a release walks the whole chain, since the
// merge pass walks it from the start. After reset and after every write of
// pool_bytes the block runs a clearing pass over all POOL_BYTES/4 header
// slots and accepts no word during it. A finished response waits in an output
// register, so the next word is taken while the previous one is unread.

module first_fit_pool_allocator
    import ffpa_pkg::*;
#(
    parameter int POOL_BYTES = POOL_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    ffpa_req_if.sink         req,
    ffpa_rsp_if.source       rsp
);

    localparam int SLOTS = POOL_BYTES / 4;
    localparam int AW    = $clog2(SLOTS);
    localparam int SW    = $clog2(POOL_BYTES + 1);
    localparam int WW    = SW + 1;
    localparam int NW    = ((SW > REQ_W) ? SW : REQ_W) + 2;
    localparam int ARENA_RST = (POOL_BYTES < RESET_POOL) ? POOL_BYTES : RESET_POOL;

    ffpa_state_t state_reg, state_next;

    logic [CFG_W-1:0] pool_reg, pool_next;
    logic [NW-1:0]    arena_reg, arena_next;
    logic [NW-1:0]    free_reg, free_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [NW-1:0]    run_start_reg, run_start_next;
    logic [NW-1:0]    run_size_reg, run_size_next;
    logic             in_run_reg, in_run_next;
    logic [NW-1:0]    acc_reg, acc_next;
    logic             ok_reg, ok_next;
    logic [NW-1:0]    grant_reg, grant_next;
    logic [AW-1:0]    clr_reg, clr_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [OFF_W-1:0]  out_grant_reg, out_grant_next;
    logic [FREE_W-1:0] out_free_reg, out_free_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;

    logic          cfg_wr;
    logic [NW-1:0] cfg_val;
    logic [NW-1:0] cfg_arena;
    logic [NW-1:0] rd_size;
    logic          rd_used;
    logic          past_end;
    logic          blk_ok;
    logic          fits;
    logic          split;
    logic [NW-1:0] off_ext;
    logic          rel_ok;
    logic [NW-1:0] req_ext;
    logic [NW-1:0] req_round;
    logic [NW-1:0] run_contrib;
    logic          out_free;

    // Header store.
    ffpa_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg[AW+1:2]),
        .rdata (ram_rdata)
    );

    // Configuration port.
    assign pready  = 1'b1;
    assign prdata  = {{(32 - CFG_W){1'b0}}, pool_reg};
    assign cfg_wr  = psel && penable && pwrite && (paddr[0] == REG_POOL_BYTES);
    assign cfg_val = NW'(pwdata[CFG_W-1:0]);

    // Pool length after saturation; too small a pool holds no blocks.
    always_comb
    begin
        if (cfg_val > NW'(POOL_BYTES))
        begin
            cfg_arena = NW'(POOL_BYTES);
        end
        else if (cfg_val < NW'(2 * HDR_BYTES))
        begin
            cfg_arena = '0;
        end
        else
        begin
            cfg_arena = cfg_val;
        end
    end

    // Decode of the header just read and of the incoming word.
    assign rd_used  = ram_rdata[SW];
    assign rd_size  = NW'(ram_rdata[SW-1:0]);
    assign past_end = (cur_reg + NW'(HDR_BYTES)) > arena_reg;
    assign blk_ok   = (rd_size >= NW'(HDR_BYTES)) && (rd_size <= (arena_reg - cur_reg));
    assign fits     = !rd_used && (rd_size >= need_reg);
    assign split    = rd_size >= (need_reg + NW'(MIN_TAIL));

    assign off_ext   = NW'(req.payload_offset);
    assign rel_ok    = (arena_reg != '0) && (off_ext >= NW'(HDR_BYTES))
                       && (req.payload_offset[1:0] == 2'b00)
                       && ((off_ext - NW'(HDR_BYTES)) < arena_reg);
    assign req_ext   = (req.request_bytes == '0) ? NW'(1) : NW'(req.request_bytes);
    assign req_round = (req_ext + NW'(3)) & ~NW'(3);

    assign run_contrib = (run_size_reg > NW'(HDR_BYTES)) ? (run_size_reg - NW'(HDR_BYTES)) : '0;
    assign out_free    = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE) && !cfg_wr;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.command == CMD_ALLOC)
                    begin
                        state_next = ST_A_RD;
                    end
                    else if (rel_ok)
                    begin
                        state_next = ST_R_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_A_RD:
            begin
                state_next = past_end ? ST_DONE : ST_A_EV;
            end
            ST_A_EV:
            begin
                if (!blk_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (fits)
                begin
                    state_next = split ? ST_A_SPLIT : ST_DONE;
                end
                else
                begin
                    state_next = ST_A_RD;
                end
            end
            ST_A_SPLIT:
            begin
                state_next = ST_DONE;
            end
            ST_R_RD:
            begin
                state_next = ST_R_EV;
            end
            ST_R_EV:
            begin
                state_next = rd_used ? ST_W_RD : ST_DONE;
            end
            ST_W_RD:
            begin
                state_next = past_end ? ST_DONE : ST_W_EV;
            end
            ST_W_EV:
            begin
                state_next = blk_ok ? ST_W_RD : ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Datapath and memory control.
    always_comb
    begin
        pool_next      = pool_reg;
        arena_next     = arena_reg;
        free_next      = free_reg;
        cur_next       = cur_reg;
        need_next      = need_reg;
        run_start_next = run_start_reg;
        run_size_next  = run_size_reg;
        in_run_next    = in_run_reg;
        acc_next       = acc_reg;
        ok_next        = ok_reg;
        grant_next     = grant_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_grant_next = out_grant_reg;
        out_free_next  = out_free_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg[AW+1:2];
        ram_wdata      = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the store; slot 0 takes the whole pool as one free block.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == '0) ? WW'(arena_reg) : '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                ok_next    = 1'b0;
                grant_next = '0;
                if (req.valid && !cfg_wr)
                begin
                    if (req.command == CMD_ALLOC)
                    begin
                        cur_next  = '0;
                        need_next = req_round + NW'(HDR_BYTES);
                    end
                    else
                    begin
                        cur_next = off_ext - NW'(HDR_BYTES);
                    end
                end
            end
            ST_A_EV:
            begin
                if (blk_ok && fits)
                begin
                    ok_next    = 1'b1;
                    grant_next = cur_reg + NW'(HDR_BYTES);
                    ram_we     = 1'b1;
                    if (split)
                    begin
                        // Tail header first, own header in the next cycle.
                        ram_waddr = AW'((cur_reg + need_reg) >> 2);
                        ram_wdata = WW'(rd_size - need_reg);
                        free_next = free_reg - (rd_size - NW'(HDR_BYTES))
                                    + (rd_size - need_reg - NW'(HDR_BYTES));
                    end
                    else
                    begin
                        ram_wdata = {1'b1, rd_size[SW-1:0]};
                        free_next = free_reg - (rd_size - NW'(HDR_BYTES));
                    end
                end
                else
                begin
                    cur_next = cur_reg + rd_size;
                end
            end
            ST_A_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, need_reg[SW-1:0]};
            end
            ST_R_EV:
            begin
                if (rd_used)
                begin
                    ok_next     = 1'b1;
                    ram_we      = 1'b1;
                    ram_wdata   = {1'b0, rd_size[SW-1:0]};
                    cur_next    = '0;
                    in_run_next = 1'b0;
                    acc_next    = '0;
                end
            end
            ST_W_RD:
            begin
                if (past_end)
                begin
                    if (in_run_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = run_start_reg[AW+1:2];
                        ram_wdata = WW'(run_size_reg);
                        free_next = acc_reg + run_contrib;
                    end
                    else
                    begin
                        free_next = acc_reg;
                    end
                end
            end
            ST_W_EV:
            begin
                if (!blk_ok || rd_used)
                begin
                    // A run of free blocks ends here: write its merged header.
                    if (in_run_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = run_start_reg[AW+1:2];
                        ram_wdata = WW'(run_size_reg);
                    end
                    acc_next    = acc_reg + (in_run_reg ? run_contrib : '0);
                    in_run_next = 1'b0;
                    free_next   = acc_reg + (in_run_reg ? run_contrib : '0);
                end
                else if (in_run_reg)
                begin
                    run_size_next = run_size_reg + rd_size;
                end
                else
                begin
                    run_start_next = cur_reg;
                    run_size_next  = rd_size;
                    in_run_next    = 1'b1;
                end
                cur_next = cur_reg + rd_size;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_grant_next = grant_reg[OFF_W-1:0];
                    out_free_next  = (free_reg > NW'(2 ** FREE_W - 1))
                                     ? {FREE_W{1'b1}} : free_reg[FREE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase

        // A pool_bytes write re-formats the pool.
        if (cfg_wr)
        begin
            pool_next  = pwdata[CFG_W-1:0];
            arena_next = cfg_arena;
            free_next  = (cfg_arena == '0) ? '0 : cfg_arena - NW'(HDR_BYTES);
            clr_next   = '0;
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pool_reg      <= CFG_W'(RESET_POOL);
            arena_reg     <= NW'(ARENA_RST);
            free_reg      <= NW'(ARENA_RST - HDR_BYTES);
            clr_reg       <= '0;
            in_run_reg    <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            arena_reg     <= arena_next;
            free_reg      <= free_next;
            clr_reg       <= clr_next;
            in_run_reg    <= in_run_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        need_reg      <= need_next;
        run_start_reg <= run_start_next;
        run_size_reg  <= run_size_next;
        acc_reg       <= acc_next;
        grant_reg     <= grant_next;
        out_ok_reg    <= out_ok_next;
        out_grant_reg <= out_grant_next;
        out_free_reg  <= out_free_next;
    end

    // Response port.
    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.granted_offset = out_grant_reg;
    assign rsp.free_space     = out_free_reg;

    // A failed request never reports an offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.granted_offset == '0))
        else $error("failed response carries an offset");

    // A pool_bytes write always starts the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (state_reg == ST_CLEAR))
        else $error("config write did not start clearing");

    // Free bytes never exceed the pool while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (free_reg <= arena_reg))
        else $error("free byte count exceeds pool");

    // A waiting response is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.free_space)))
        else $error("pending response lost");

endmodule

`default_nettype wire

### design/ffpa_ram.sv
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
